// ===== hw/rtl/vdm_pkg.sv =====
package vdm_pkg;

  localparam int unsigned ElemW   = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned DenW    = 17;
  localparam int unsigned TermW   = 32;
  localparam int unsigned AccW    = 48;
  localparam int unsigned MetricW = 2;
  localparam int unsigned RootW   = 32;
  localparam int unsigned RadW    = 64;
  localparam int unsigned SubW    = 36;
  localparam int unsigned QuotW   = 17;

  localparam int unsigned DivSteps  = QuotW;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned CntW      = $clog2(SqrtSteps);

  typedef enum logic [MetricW-1:0] {
    MetricEuclid   = 2'd0,
    MetricManhattan = 2'd1,
    MetricCheby    = 2'd2,
    MetricCanberra = 2'd3
  } metric_e;

endpackage

// ===== hw/rtl/vdm_if.sv =====
interface vdm_in_if;
  import vdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] a_elem;
  logic signed [ElemW-1:0] b_elem;
  logic                    last;

  modport source (output valid, a_elem, b_elem, last, input ready);
  modport sink   (input valid, a_elem, b_elem, last, output ready);
endinterface

interface vdm_out_if;
  import vdm_pkg::*;

  logic            valid;
  logic            ready;
  logic [AccW-1:0] distance;
  logic            saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

// ===== hw/rtl/vector_distance_metrics_core.sv =====
// Vector distance engine: one coordinate pair (a_elem, b_elem, signed Q8.8) per input transfer,
// with last on the final pair; one result transfer per vector carries the distance as unsigned
// fixed point with 16 fraction bits plus a saturation flag, after which the accumulator clears.
// metric selects euclidean (0), manhattan (1), chebyshev (2) or canberra (3); the user must write
// it only between vectors, as the block does not enforce this. The block works on one pair at a
// time: accept, operand prep, term, accumulate; a canberra pair with a nonzero operand also runs
// the divider, which produces the quotient one bit a cycle over 17 steps. The final pair adds an
// output step, and under euclidean the square root, one root bit a cycle. Divider and square
// root share a single 36-bit trial subtractor. A new pair is accepted while the previous result
// still waits in the output register; the output cycle stalls only if that register is full.
module vector_distance_metrics_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vdm_pkg::MetricW-1:0]  cfg_wdata_i,
  vdm_in_if.sink                       in_i,
  vdm_out_if.source                    out_o
);
  import vdm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StTerm = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StAcc  = 3'd4;
  localparam logic [2:0] StSqrt = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]              state_q, state_d;
  metric_e                 metric_q;
  logic [AccW-1:0]         acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic                    out_valid_q, out_valid_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  logic signed [ElemW-1:0] a_q, a_d, b_q, b_d;
  logic                    last_q, last_d;
  logic [MagW-1:0]         dmag_q, dmag_d;
  logic [DenW-1:0]         den_q, den_d;
  logic [TermW-1:0]        term_q, term_d;
  logic [SubW-1:0]         rem_q, rem_d;
  logic [RootW-1:0]        root_q, root_d;
  logic [RadW-1:0]         rad_q, rad_d;
  logic [AccW-1:0]         dist_q, dist_d;
  logic                    sat_q, sat_d;

  // shared trial subtractor
  logic [SubW-1:0]         sub_a, sub_b, sub_diff;
  logic                    sub_borrow, sub_ge;

  logic signed [ElemW:0]   diff;
  logic [ElemW:0]          diff_mag;
  logic [MagW-1:0]         a_mag, b_mag;
  logic [AccW:0]           acc_sum;
  logic [AccW-1:0]         acc_next;
  logic                    acc_ovf;
  logic [QuotW:0]          div_cand;
  logic                    in_xfer;

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);

  assign out_o.valid     = out_valid_q;
  assign out_o.distance  = dist_q;
  assign out_o.saturated = sat_q;

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_borrow;

  assign diff     = {a_q[ElemW-1], a_q} - {b_q[ElemW-1], b_q};
  assign diff_mag = diff[ElemW] ? (ElemW+1)'(-diff) : (ElemW+1)'(diff);
  assign a_mag    = a_q[ElemW-1] ? MagW'(-{a_q[ElemW-1], a_q}) : MagW'(a_q);
  assign b_mag    = b_q[ElemW-1] ? MagW'(-{b_q[ElemW-1], b_q}) : MagW'(b_q);

  // first divider step compares the dividend itself, later steps the doubled remainder
  assign div_cand = (cnt_q == '0) ? rem_q[QuotW:0] : {rem_q[QuotW-1:0], 1'b0};

  assign acc_sum = {1'b0, acc_q} + (AccW+1)'(term_q);

  always_comb begin
    acc_next = acc_q;
    acc_ovf  = 1'b0;
    if (metric_q == MetricCheby) begin
      if (AccW'(term_q) > acc_q) acc_next = AccW'(term_q);
    end else if (acc_sum[AccW]) begin
      acc_next = '1;
      acc_ovf  = 1'b1;
    end else begin
      acc_next = acc_sum[AccW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    dmag_d      = dmag_q;
    den_d       = den_q;
    term_d      = term_q;
    rem_d       = rem_q;
    root_d      = root_q;
    rad_d       = rad_q;
    dist_d      = dist_q;
    sat_d       = sat_q;
    sub_a       = '0;
    sub_b       = '0;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          a_d     = in_i.a_elem;
          b_d     = in_i.b_elem;
          last_d  = in_i.last;
          state_d = StPrep;
        end
      end
      StPrep: begin
        dmag_d  = diff_mag[MagW-1:0];
        den_d   = DenW'(a_mag) + DenW'(b_mag);
        state_d = StTerm;
      end
      StTerm: begin
        cnt_d   = '0;
        state_d = StAcc;
        case (metric_q) inside
          MetricEuclid:    term_d = TermW'(dmag_q) * TermW'(dmag_q);
          MetricManhattan,
          MetricCheby:     term_d = TermW'({dmag_q, 8'h00});
          default: begin
            term_d = '0;
            if (den_q != '0) begin
              rem_d   = SubW'(dmag_q);
              state_d = StDiv;
            end
          end
        endcase
      end
      StDiv: begin
        sub_a  = SubW'(div_cand);
        sub_b  = SubW'(den_q);
        rem_d  = sub_ge ? sub_diff : SubW'(div_cand);
        term_d = {term_q[TermW-2:0], sub_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = StAcc;
      end
      StAcc: begin
        acc_d = acc_next;
        ovf_d = ovf_q | acc_ovf;
        cnt_d = '0;
        if (!last_q) begin
          state_d = StIdle;
        end else if (metric_q == MetricEuclid) begin
          rem_d   = '0;
          root_d  = '0;
          rad_d   = {acc_next, 16'h0000};
          state_d = StSqrt;
        end else begin
          state_d = StOut;
        end
      end
      StSqrt: begin
        sub_a  = {rem_q[SubW-3:0], rad_q[RadW-1 -: 2]};
        sub_b  = SubW'({root_q, 2'b01});
        rem_d  = sub_ge ? sub_diff : sub_a;
        root_d = {root_q[RootW-2:0], sub_ge};
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_o.ready) begin
          dist_d      = (metric_q == MetricEuclid) ? AccW'(root_q) : acc_q;
          sat_d       = ovf_q;
          out_valid_d = 1'b1;
          acc_d       = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      metric_q    <= MetricEuclid;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) metric_q <= metric_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    last_q <= last_d;
    dmag_q <= dmag_d;
    den_q  <= den_d;
    term_q <= term_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
    dist_q <= dist_d;
    sat_q  <= sat_d;
  end

`ifndef SYNTH
  // a canberra term never exceeds 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == CntW'(DivSteps - 1))
      |=> (term_q <= TermW'(32'h0001_0000)))
    else $error("canberra quotient above one");

  // chebyshev takes a maximum and never clips
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAcc && metric_q == MetricCheby && !ovf_q) |=> !ovf_q)
    else $error("chebyshev update flagged saturation");

  // a pair without last never produces a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !in_i.last) |=> !$rose(out_o.valid))
    else $error("result without final pair");

  // loading a result always leaves the accumulator cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && state_d == StIdle) |=> (acc_q == '0 && !ovf_q))
    else $error("accumulator not cleared after result");
`endif

endmodule

// ===== tb/vector_distance_metrics_core_test.sv =====
`timescale 1ns / 100ps

module vector_distance_metrics_core_test;
  import vdm_pkg::*;

  localparam int unsigned IdleCycles = 60;
  localparam longint unsigned CycleLimit = 3_000_000;
  localparam logic [AccW-1:0] AccMax = '1;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned Phases = 8;

  typedef struct {
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    logic                    last;
    int unsigned             gap;
  } pair_t;

  typedef struct {
    logic [AccW-1:0] distance;
    logic            saturated;
  } dist_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [MetricW-1:0] cfg_wdata;

  vdm_in_if  pair_ch ();
  vdm_out_if dist_ch ();

  vector_distance_metrics_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pair_ch),
    .out_o       (dist_ch)
  );

  pair_t pair_queue[$];
  dist_t dist_queue[$];

  // shadow of the block state
  metric_e         cur_metric = MetricEuclid;
  logic [AccW-1:0] acc_model  = '0;
  logic            ovf_model  = 1'b0;

  bit              calm = 1'b0;
  bit              pair_fire = 1'b0;
  int unsigned     gap_cnt = 0;
  int unsigned     stall_left = 0;
  int unsigned     errors = 0;
  int unsigned     pairs_in = 0;
  int unsigned     vectors_done = 0;
  int unsigned     sat_seen = 0;
  longint unsigned cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic signed [ElemW-1:0] draw_elem();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = int'($urandom_range(0, 2047)) - 1024;
      2: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v[ElemW-1:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic accumulate_term(input logic [63:0] term);
    logic [63:0] sum;
    sum = {16'd0, acc_model} + term;
    if (sum > {16'd0, AccMax}) begin
      acc_model = AccMax;
      ovf_model = 1'b1;
    end else begin
      acc_model = sum[AccW-1:0];
    end
  endtask

  task automatic fold_pair(input logic signed [ElemW-1:0] a, input logic signed [ElemW-1:0] b,
                           input logic last);
    logic signed [17:0] diff;
    logic signed [17:0] ma;
    logic signed [17:0] mb;
    logic [63:0]        d;
    logic [63:0]        dist_val;
    dist_t              res;
    diff = a - b;
    ma = a;
    mb = b;
    if (diff < 0) diff = -diff;
    if (ma < 0) ma = -ma;
    if (mb < 0) mb = -mb;
    d = {46'd0, diff};
    case (cur_metric)
      MetricEuclid:    accumulate_term(d * d);
      MetricManhattan: accumulate_term(d << 8);
      MetricCheby: begin
        if ((d << 8) > {16'd0, acc_model}) acc_model = d[39:0] << 8;
      end
      default: begin
        // both operands zero contribute nothing
        if (a != 0 || b != 0) accumulate_term((d << 16) / ({46'd0, ma} + {46'd0, mb}));
      end
    endcase
    if (last) begin
      if (cur_metric == MetricEuclid) dist_val = floor_root({acc_model, 16'd0});
      else dist_val = {16'd0, acc_model};
      res.distance  = dist_val[AccW-1:0];
      res.saturated = ovf_model;
      dist_queue.insert(dist_queue.size(), res);
      acc_model = '0;
      ovf_model = 1'b0;
    end
  endtask

  task automatic queue_pair(input int a, input int b, input logic last);
    pair_t p;
    p.a    = a[ElemW-1:0];
    p.b    = b[ElemW-1:0];
    p.last = last;
    p.gap  = draw_gap();
    pair_queue.insert(pair_queue.size(), p);
  endtask

  task automatic queue_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      queue_pair(int'(draw_elem()), int'(draw_elem()), i == len - 1);
    end
  endtask

  task automatic write_metric(input metric_e m);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    cur_metric = m;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // hold off until every pair is in, every distance is out and the core has drained
  task automatic settle();
    while (pair_queue.size() != 0 || pair_ch.valid || dist_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  // pair driver
  always @(negedge clk_i) begin : pair_driver
    pair_t nxt;
    if (!rst_ni) begin
      pair_ch.valid  <= 1'b0;
      pair_ch.a_elem <= '0;
      pair_ch.b_elem <= '0;
      pair_ch.last   <= 1'b0;
    end else if (!pair_ch.valid || pair_fire) begin
      if (pair_queue.size() == 0) begin
        pair_ch.valid <= 1'b0;
      end else if (gap_cnt < pair_queue[0].gap) begin
        gap_cnt++;
        pair_ch.valid <= 1'b0;
      end else begin
        nxt = pair_queue.pop_front();
        gap_cnt = 0;
        pair_ch.a_elem <= nxt.a;
        pair_ch.b_elem <= nxt.b;
        pair_ch.last   <= nxt.last;
        pair_ch.valid  <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) dist_ch.ready <= 1'b0;
    else dist_ch.ready <= (stall_left == 0);
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin : transfer_monitor
    dist_t want;
    if (rst_ni) begin
      pair_fire = pair_ch.valid && pair_ch.ready;
      if (pair_fire) begin
        pairs_in++;
        fold_pair(pair_ch.a_elem, pair_ch.b_elem, pair_ch.last);
      end
      if (dist_ch.valid && dist_ch.ready) begin
        if (dist_queue.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected distance %h sat %b", dist_ch.distance, dist_ch.saturated);
          end
        end else begin
          want = dist_queue.pop_front();
          if (dist_ch.distance !== want.distance || dist_ch.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10) begin
              $display("distance mismatch: expected %h sat %b, got %h sat %b",
                       want.distance, want.saturated, dist_ch.distance, dist_ch.saturated);
            end
          end
          vectors_done++;
          if (want.saturated) sat_seen++;
        end
        stall_left = draw_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("[vector_distance_metrics_core] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes under each metric
    write_metric(MetricEuclid);
    queue_pair(32767, -32768, 1'b1);
    queue_pair(0, 0, 1'b1);
    queue_pair(-32768, 32767, 1'b0);
    queue_pair(3, 4, 1'b0);
    queue_pair(-1, 1, 1'b1);
    settle();
    write_metric(MetricManhattan);
    queue_pair(32767, -32768, 1'b1);
    queue_pair(100, -100, 1'b0);
    queue_pair(0, -32768, 1'b1);
    settle();
    write_metric(MetricCheby);
    queue_pair(5, 1, 1'b0);
    queue_pair(-32768, 32767, 1'b0);
    queue_pair(7, 7, 1'b1);
    queue_pair(0, 0, 1'b1);
    settle();
    write_metric(MetricCanberra);
    queue_pair(0, 0, 1'b1);
    queue_pair(0, 0, 1'b0);
    queue_pair(5, -5, 1'b1);
    queue_pair(-32768, 32767, 1'b1);
    queue_pair(1, 1, 1'b0);
    queue_pair(0, 300, 1'b1);
    // metric switched with a vector half done
    queue_pair(3, 1, 1'b0);
    settle();
    write_metric(MetricEuclid);
    queue_pair(256, 0, 1'b0);
    settle();
    write_metric(MetricManhattan);
    queue_pair(1, 2, 1'b1);
    settle();

    // random vectors, mostly short, in phases with the metric changed between them
    for (int unsigned p = 0; p < Phases; p++) begin
      write_metric(p < 4 ? metric_e'(p) : metric_e'($urandom_range(0, 3)));
      calm = (p == 2 || p == 5);
      n = 0;
      while (n < PhaseItems) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        queue_vector(len);
        n += len;
      end
      settle();
    end

    errors += dist_queue.size();
    $display("%0d coordinate pairs, %0d distances checked over all four metrics", pairs_in,
             vectors_done);
    $display("%0d saturated results, gaps and stalls of 0..11 cycles on both channels",
             sat_seen);
    if (errors == 0) begin
      $display("[vector_distance_metrics_core] OK");
    end else begin
      $display("[vector_distance_metrics_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vdm_pkg.sv
hw/rtl/vdm_if.sv
hw/rtl/vector_distance_metrics_core.sv
tb/vector_distance_metrics_core_test.sv
